// File: design/fci_pkg.sv
// ----------------------------------------------------------------------------
// fci_pkg: shared types and constants of the int16 FIR convolution block
// Widths, the item mode code and the structs passed along the tap chain.
// ----------------------------------------------------------------------------
package fci_pkg;

  localparam int MAX_TAPS = 64;
  localparam int DATA_W   = 16;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_t;

  // Control broadcast to every tap in the cycle an item is accepted.
  typedef struct packed {
    logic              shift;
    logic              load;
    logic [IDX_W-1:0]  load_idx;
    logic [DATA_W-1:0] coef;
  } tap_ctl_t;

  // Accumulation wave that walks one tap per cycle unless the chain is stalled.
  typedef struct packed {
    logic              vld;
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] psum;
  } wave_t;

endpackage

// File: design/fci_cell.sv
// ----------------------------------------------------------------------------
// fci_cell: one tap of the FIR chain
// Holds one coefficient and one delayed sample and adds their product to the
// partial sum that passes through it while the wave still has taps to count.
// ----------------------------------------------------------------------------
module fci_cell
  import fci_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  tap_ctl_t          ctl,
  input  logic [IDX_W-1:0]  cell_idx,
  input  logic [DATA_W-1:0] x_in,
  output logic [DATA_W-1:0] x_out,
  input  wave_t             wave_in,
  output wave_t             wave_out
);

  logic signed [DATA_W-1:0]   coef_r;
  logic signed [DATA_W-1:0]   x_r;
  logic signed [2*DATA_W-1:0] prod;
  wave_t                      wave_r;
  wave_t                      wave_nxt;

  always_ff @(posedge clk) begin
    if (ctl.load && (ctl.load_idx == cell_idx)) begin
      coef_r <= $signed(ctl.coef);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
    end else if (ctl.shift) begin
      x_r <= $signed(x_in);
    end
  end

  assign prod = coef_r * x_r;

  always_comb begin
    wave_nxt     = wave_in;
    if (wave_in.cnt != '0) begin
      wave_nxt.cnt = wave_in.cnt - CNT_W'(1);
      if (wave_in.vld) begin
        wave_nxt.psum = wave_in.psum + prod[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= '0;
    end else if (adv) begin
      wave_r <= wave_nxt;
    end
  end

  assign x_out    = x_r;
  assign wave_out = wave_r;

endmodule

// File: design/fir_convolution_int16_top.sv
// ----------------------------------------------------------------------------
// fir_convolution_int16_top: causal FIR filter over 16-bit signed samples
// Load items write coefficients, sample items yield one wrapped 16-bit sum.
// ----------------------------------------------------------------------------
// A sample's sum passes start_r, the wave register of every tap and the
//   output register before out_tvalid rises. No new item is taken until
//   the wave has walked the 64-tap chain, one tap per cycle unless stalled.
// A stalled result holds the wave in the last tap until out_tready is high.
// Reset (rst_n low, synchronous) clears the sample history, sets taps_in_use
//   to 1 and empties the output; coefficients stay undefined until loaded.
module fir_convolution_int16_top
  import fci_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Configuration: taps_in_use.
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  // Input items.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,   // tap_index[5:0], coefficient[21:6],
                                        // sample[37:22], zero fill[39:38]
  input  logic [1:0]        in_tuser,   // mode[0], first[1]
  // Result items.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata   // filtered[15:0]
);

  // Unpacked input fields.
  logic [IDX_W-1:0]  in_tap_index;
  logic [DATA_W-1:0] in_coef;
  logic [DATA_W-1:0] in_sample;
  mode_t             in_mode;
  logic              in_first;

  assign in_tap_index = in_tdata[5:0];
  assign in_coef      = in_tdata[21:6];
  assign in_sample    = in_tdata[37:22];
  assign in_mode      = mode_t'(in_tuser[0]);
  assign in_first     = in_tuser[1];

  // Control registers.
  logic [CNT_W-1:0]  taps_r;
  logic              busy_r;     // a sample's wave is in the chain
  logic              start_r;    // launch the wave into the first tap
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;

  logic              in_acc;
  logic              sample_acc;
  logic              load_acc;
  logic              adv;
  logic              last_vld;
  logic              out_load;
  logic [CNT_W-1:0]  taps_eff;
  tap_ctl_t          ctl;

  logic [DATA_W-1:0] x_q    [MAX_TAPS];
  wave_t             wave_q [MAX_TAPS+1];

  // The chain is only touched while no wave is in flight, so a new item is
  // taken whenever the previous sample's sum has left the chain, even if the
  // output register still holds it.
  assign in_tready  = !busy_r;
  assign in_acc     = in_tvalid && in_tready;
  assign sample_acc = in_acc && (in_mode == MODE_SAMPLE);
  assign load_acc   = in_acc && (in_mode == MODE_LOAD);

  assign ctl.shift    = sample_acc;
  assign ctl.load     = load_acc;
  assign ctl.load_idx = in_tap_index;
  assign ctl.coef     = in_coef;

  // More taps than the chain holds saturates to the chain length.
  assign taps_eff = (taps_r > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : taps_r;

  // The wave enters the first tap in the cycle after the shift, so every tap
  // already holds its updated sample when the wave passes.
  assign wave_q[0].vld  = start_r;
  assign wave_q[0].cnt  = taps_eff;
  assign wave_q[0].psum = '0;

  // The whole chain freezes only while the finished sum waits at the end
  // and the output register is still full.
  assign last_vld = wave_q[MAX_TAPS].vld;
  assign adv      = !(last_vld && out_valid_r && !out_tready);
  assign out_load = last_vld && adv;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
    logic [DATA_W-1:0] x_in;

    // The newest sample enters tap 0; a first flag zeroes the older history.
    if (k == 0) begin : g_head
      assign x_in = in_sample;
    end else begin : g_body
      assign x_in = in_first ? '0 : x_q[k-1];
    end

    fci_cell u_tap (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .ctl      (ctl),
      .cell_idx (IDX_W'(k)),
      .x_in     (x_in),
      .x_out    (x_q[k]),
      .wave_in  (wave_q[k]),
      .wave_out (wave_q[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r      <= CNT_W'(1);
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        taps_r <= cfg_wr_data;
      end
      start_r <= sample_acc;
      if (sample_acc) begin
        busy_r <= 1'b1;
      end else if (out_load) begin
        busy_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= wave_q[MAX_TAPS].psum;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A wave only ever leaves the chain while a sample is being processed.
  a_exit_busy : assert property (@(posedge clk) disable iff (!rst_n)
    last_vld |-> busy_r)
    else $error("wave left the chain while no sample was in flight");

  // Only one wave is ever in the chain.
  a_one_wave : assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> !last_vld && busy_r)
    else $error("second wave launched while one is in flight");

  // Every tap count is used up before the wave reaches the end.
  a_cnt_spent : assert property (@(posedge clk) disable iff (!rst_n)
    last_vld |-> (wave_q[MAX_TAPS].cnt == '0))
    else $error("wave reached the end with taps left over");

  // An accepted sample launches its wave in the next cycle.
  a_launch : assert property (@(posedge clk) disable iff (!rst_n)
    sample_acc |=> start_r)
    else $error("accepted sample did not launch a wave");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the int16 FIR convolution block
// A short table of directed items is followed by random phases, each at its
// own taps_in_use setting. Every accepted item goes through a local filter
// predictor, and every result is checked in order against its predictions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import fci_pkg::*;

  localparam int HALF_PERIOD     = 10;
  // Long enough for one full wave to pass through the block.
  localparam int SETTLE_CYCLES   = 80;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int REPORT_LIMIT    = 10;

  // Kind of a row in the directed table.
  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  // One input item, with its fields unpacked.
  typedef struct packed {
    mode_t             mode;
    logic [IDX_W-1:0]  tap;
    logic [DATA_W-1:0] coef;
    logic [DATA_W-1:0] smp;
    logic              first;
  } fir_item_t;

  // One row of the directed table. A row that carries a typed result uses
  // it in place of the predictor's value.
  typedef struct packed {
    row_kind_t         kind;
    fir_item_t         item;
    logic              typed;
    logic [DATA_W-1:0] want;
    logic [CNT_W-1:0]  taps;
  } stim_row_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0]  cfg_wr_data = '0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata    = '0;   // tap_index[5:0], coefficient[21:6],
                                         // sample[37:22], zero fill[39:38]
  logic [1:0]        in_tuser    = '0;   // mode[0], first[1]
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [DATA_W-1:0] out_tdata;          // filtered[15:0]

  // Predictor state: the coefficients, the delay line (entry 0 is the newest
  // sample) and the kernel length as last written.
  logic [DATA_W-1:0] coef_mem   [MAX_TAPS];
  logic [DATA_W-1:0] delay_line [MAX_TAPS];
  bit                tap_loaded [MAX_TAPS];
  logic [CNT_W-1:0]  taps_cfg;

  // Filtered values still owed by the block, oldest first.
  logic [DATA_W-1:0] expected_filtered [$];

  int mismatches  = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_asked  = 0;
  int hold_given  = 0;
  int hold_left   = 0;

  fir_convolution_int16_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Watchdog. Nothing else bounds the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Applies one accepted item to the predictor. Loads only update the tap
  // store; a sample clears the history when first is set, shifts into the
  // delay line and yields the 16-bit wrapped sum over the taps in use.
  function automatic bit predict_filtered(input fir_item_t it,
                                          output logic [DATA_W-1:0] filtered);
    logic [DATA_W-1:0] acc;
    logic signed [31:0] prod;
    int n;
    if (it.mode == MODE_LOAD) begin
      coef_mem[it.tap]   = it.coef;
      tap_loaded[it.tap] = 1'b1;
      filtered = '0;
      return 1'b0;
    end
    if (it.first) begin
      for (int k = 0; k < MAX_TAPS; k++) delay_line[k] = '0;
    end
    for (int k = MAX_TAPS - 1; k > 0; k--) delay_line[k] = delay_line[k-1];
    delay_line[0] = it.smp;
    // Settings above the store size saturate to the full kernel.
    n = (int'(taps_cfg) > MAX_TAPS) ? MAX_TAPS : int'(taps_cfg);
    acc = '0;
    for (int k = 0; k < n; k++) begin
      prod = $signed(coef_mem[k]) * $signed(delay_line[k]);
      acc += prod[DATA_W-1:0];
    end
    filtered = acc;
    return 1'b1;
  endfunction

  // Offers one item after a random gap, waits for the handshake and records
  // what the block owes for it.
  task automatic send_item(input fir_item_t it, input logic typed,
                           input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, it.smp, it.coef, it.tap};
    in_tuser  <= {it.first, it.mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (predict_filtered(it, predicted)) begin
      expected_filtered.push_back(typed ? want : predicted);
    end
  endtask

  // Changes the kernel length only once the block has gone quiet: every
  // result is in, and a trailing load has had time to land.
  task automatic write_taps(input logic [CNT_W-1:0] value);
    in_tvalid <= 1'b0;
    while (expected_filtered.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    taps_cfg  = value;
  endtask

  // Full-scale values turn up often, since they are the ones that wrap.
  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      default: return DATA_W'($urandom());
    endcase
  endfunction

  // Mostly samples, with coefficient reloads scattered in and a new block
  // started now and then. Ignored fields carry random bits as well.
  function automatic fir_item_t random_item();
    fir_item_t it;
    it.mode  = ($urandom_range(99) < 22) ? MODE_LOAD : MODE_SAMPLE;
    it.tap   = IDX_W'($urandom());
    it.coef  = random_word();
    it.smp   = random_word();
    it.first = (it.mode == MODE_SAMPLE) ? ($urandom_range(15) == 0)
                                        : 1'($urandom());
    return it;
  endfunction

  // Result side. A pending hold-off request turns into a long stretch with
  // out_tready low; otherwise the receiver stalls at the current rate.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_asked != hold_given) begin
      hold_given <= hold_asked;
      hold_left  <= HOLD_OFF_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker: each accepted result is matched against the oldest
  // prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_filtered.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result: filtered %h with nothing pending", out_tdata);
      end else begin
        if (out_tdata !== expected_filtered[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < REPORT_LIMIT)
            $display("mismatch: filtered expected %h got %h",
                     expected_filtered[0], out_tdata);
        end
        void'(expected_filtered.pop_front());
      end
    end
  end

  // Directed items. Typed results hold for extremes that can be worked out
  // by hand: a unit tap passing the sample through, the full-scale products
  // that wrap to 0 and to 0x8000, and a zero kernel length.
  stim_row_t directed_rows [17];

  initial begin
    fir_item_t it;
    logic [CNT_W-1:0] phase_taps [PHASES];
    int limit;

    for (int k = 0; k < MAX_TAPS; k++) begin
      coef_mem[k]   = '0;
      delay_line[k] = '0;
      tap_loaded[k] = 1'b0;
    end
    taps_cfg = CNT_W'(1);

    directed_rows = '{
      // Unit tap; first is set on the load and must have no effect.
      '{ROW_ITEM, '{MODE_LOAD,   6'h00, 16'h0001, 16'hFFFF, 1'b1}, 1'b0, 16'h0000, 7'd0},
      '{ROW_ITEM, '{MODE_SAMPLE, 6'h2A, 16'h5555, 16'h7FFF, 1'b1}, 1'b1, 16'h7FFF, 7'd0},
      '{ROW_ITEM, '{MODE_SAMPLE, 6'h15, 16'hAAAA, 16'h8000, 1'b0}, 1'b1, 16'h8000, 7'd0},
      // Most negative coefficient: the products wrap to 0 and to 0x8000.
      '{ROW_ITEM, '{MODE_LOAD,   6'h00, 16'h8000, 16'h1234, 1'b1}, 1'b0, 16'h0000, 7'd0},
      '{ROW_ITEM, '{MODE_SAMPLE, 6'h3F, 16'hFFFF, 16'h8000, 1'b0}, 1'b1, 16'h0000, 7'd0},
      '{ROW_ITEM, '{MODE_SAMPLE, 6'h00, 16'h0000, 16'h7FFF, 1'b0}, 1'b1, 16'h8000, 7'd0},
      // Top slot and a second tap.
      '{ROW_ITEM, '{MODE_LOAD,   6'h3F, 16'h7FFF, 16'h0000, 1'b0}, 1'b0, 16'h0000, 7'd0},
      '{ROW_ITEM, '{MODE_LOAD,   6'h01, 16'hFFFF, 16'h0000, 1'b0}, 1'b0, 16'h0000, 7'd0},
      // A zero kernel length gives zero whatever the sample.
      '{ROW_CFG,  '{MODE_SAMPLE, 6'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, 16'h0000, 7'd0},
      '{ROW_ITEM, '{MODE_SAMPLE, 6'h3F, 16'h1234, 16'h7FFF, 1'b0}, 1'b1, 16'h0000, 7'd0},
      // Two taps: history, and its clearing by first.
      '{ROW_CFG,  '{MODE_SAMPLE, 6'h00, 16'h0000, 16'h0000, 1'b0}, 1'b0, 16'h0000, 7'd2},
      '{ROW_ITEM, '{MODE_SAMPLE, 6'h00, 16'h0000, 16'h0003, 1'b1}, 1'b0, 16'h0000, 7'd0},
      '{ROW_ITEM, '{MODE_SAMPLE, 6'h00, 16'h0000, 16'hFFFB, 1'b0}, 1'b0, 16'h0000, 7'd0},
      '{ROW_ITEM, '{MODE_SAMPLE, 6'h00, 16'h0000, 16'h0002, 1'b1}, 1'b0, 16'h0000, 7'd0},
      '{ROW_ITEM, '{MODE_LOAD,   6'h00, 16'h7FFF, 16'hABCD, 1'b0}, 1'b0, 16'h0000, 7'd0},
      '{ROW_ITEM, '{MODE_SAMPLE, 6'h00, 16'h0000, 16'h0001, 1'b1}, 1'b1, 16'h7FFF, 7'd0},
      '{ROW_ITEM, '{MODE_SAMPLE, 6'h00, 16'h0000, 16'h0001, 1'b0}, 1'b1, 16'h7FFE, 7'd0}
    };

    // Kernel lengths per random phase: full store, short kernels, settings
    // past the store size that must saturate, one tap and zero taps.
    phase_taps = '{7'd64, 7'd5, 7'd127, 7'd1, 7'd0, 7'd0, 7'd2, 7'd100, 7'd64};
    phase_taps[5] = CNT_W'($urandom_range(3, 63));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed part runs with the first idling profile: a slow sender
    // and a receiver that stalls most of the time.
    tx_idle_pct = 37;
    rx_idle_pct <= 86;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG)
        write_taps(directed_rows[r].taps);
      else
        send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      // Three phases per idling profile: sender slow and receiver slower,
      // then the other way round, then full speed on both sides.
      case (p / 3)
        0: begin
          tx_idle_pct = 37;
          rx_idle_pct <= 86;
        end
        1: begin
          tx_idle_pct = 86;
          rx_idle_pct <= 37;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      write_taps(phase_taps[p]);

      // Every tap in use must hold a coefficient before any sample reads it.
      limit = (int'(phase_taps[p]) > MAX_TAPS) ? MAX_TAPS : int'(phase_taps[p]);
      for (int k = 0; k < limit; k++) begin
        if (!tap_loaded[k]) begin
          it = random_item();
          it.mode = MODE_LOAD;
          it.tap  = IDX_W'(k);
          send_item(it, 1'b0, '0);
        end
      end

      // In the first full-speed phase the receiver shuts off for a long
      // stretch while samples keep coming, so the block fills and has to
      // hold its input back.
      if (p == 6) hold_asked <= hold_asked + 1;

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_item(random_item(), 1'b0, '0);
      end
    end

    // Drain: wait for the last results, then give the block time to show
    // anything it should not send.
    in_tvalid <= 1'b0;
    while (expected_filtered.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_filtered.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: fir_convolution_int16_top.f
design/fci_pkg.sv
design/fci_cell.sv
design/fir_convolution_int16_top.sv
dv/tb_top.sv
